// ----- src/ps2dt_pkg.sv -----
// Shared constants and opcodes for the PS/2 device-side transceiver.
package ps2dt_pkg;

  // Default depth of the transmit queue.
  localparam int TX_QUEUE_DEPTH_DEF = 16;

  // Width of the queue count at the default depth.
  localparam int TX_COUNT_W_DEF = $clog2(TX_QUEUE_DEPTH_DEF + 1);

  // Request opcodes.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_PUSH = 1'b1;

endpackage

// ----- src/ps2dt_if.sv -----
// Request and result channel interfaces of the PS/2 device-side transceiver.
interface ps2dt_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic       clock_line;
  logic       data_line;
  logic [7:0] tx_byte;

  modport source (output valid, output opcode, output clock_line, output data_line,
                  output tx_byte, input ready);
  modport sink (input valid, input opcode, input clock_line, input data_line,
                input tx_byte, output ready);
endinterface

interface ps2dt_rsp_if import ps2dt_pkg::*; #(
  parameter int COUNT_W = TX_COUNT_W_DEF
);
  logic               valid;
  logic               ready;
  logic               clock_pull_low;
  logic               data_pull_low;
  logic               rx_valid;
  logic [7:0]         rx_data;
  logic               parity_error;
  logic [COUNT_W-1:0] tx_queue_count;
  logic               tx_dropped;

  modport source (output valid, output clock_pull_low, output data_pull_low,
                  output rx_valid, output rx_data, output parity_error,
                  output tx_queue_count, output tx_dropped, input ready);
  modport sink (input valid, input clock_pull_low, input data_pull_low,
                input rx_valid, input rx_data, input parity_error,
                input tx_queue_count, input tx_dropped, output ready);
endinterface

// ----- src/ps2_device_side_transceiver.sv -----
// PS/2 device-side transceiver: line state machine, transmit queue and result register.
//
// Usage: the req channel carries one request per half-bit period (opcode tick) with
// the sampled clock and data line levels, or a push (opcode push) that appends
// tx_byte to the transmit queue. Every request produces exactly one result on the
// rsp channel: the clock and data pull-low drives, a received byte with rx_valid,
// a parity_error pulse, the queue count after the request and a tx_dropped pulse.
// An accepted request's result is registered and shows in the cycle after it is
// accepted. Throughput is one request per cycle while the receiver does not stall; the
// phase step and the queue access both finish between the request and the result
// register, and the head byte of the queue is held in a registered read of the queue memory.
// The result register is a single stage: req.ready is high while it is empty or
// being taken, so when the receiver stalls the block holds its result and takes
// no new request until rsp.ready returns.
// Reset puts the line machine in idle with both lines released and empties the
// queue; there is no clearing pass and requests are taken at the first cycle
// after reset.
module ps2_device_side_transceiver import ps2dt_pkg::*; #(
  parameter int TX_QUEUE_DEPTH = TX_QUEUE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  ps2dt_req_if.sink    req,
  ps2dt_rsp_if.source  rsp
);

  localparam int AW = $clog2(TX_QUEUE_DEPTH);
  localparam int CW = $clog2(TX_QUEUE_DEPTH + 1);

  // Phase codes.
  localparam logic [4:0] PH_IDLE_START = 5'd0;
  localparam logic [4:0] PH_IDLE_WAIT  = 5'd1;
  localparam logic [4:0] PH_IDLE_READY = 5'd2;
  localparam logic [4:0] PH_RX_START   = 5'd3;
  localparam logic [4:0] PH_RX_D0      = 5'd5;
  localparam logic [4:0] PH_RX_D7      = 5'd12;
  localparam logic [4:0] PH_RX_PARITY  = 5'd13;
  localparam logic [4:0] PH_RX_STOP    = 5'd14;
  localparam logic [4:0] PH_RX_ACK     = 5'd15;
  localparam logic [4:0] PH_TX_START   = 5'd16;
  localparam logic [4:0] PH_TX_D7      = 5'd23;
  localparam logic [4:0] PH_TX_PARITY  = 5'd24;
  localparam logic [4:0] PH_TX_AFTER   = 5'd26;

  // Line machine state.
  logic [4:0]    phase, phase_next;
  logic          clk_released, clk_released_next;
  logic          clock_drive, clock_drive_next;
  logic          data_drive, data_drive_next;
  logic          bad_frame, bad_frame_next;
  logic [7:0]    receive_shift, receive_shift_next;
  logic [7:0]    send_shift, send_shift_next;
  logic          parity_acc, parity_acc_next;

  // Transmit queue.
  logic [7:0]    tx_mem [TX_QUEUE_DEPTH];
  logic [7:0]    head_data;
  logic [AW-1:0] queue_head, queue_head_next;
  logic [AW-1:0] queue_tail, queue_tail_next;
  logic [CW-1:0] queue_fill, queue_fill_next;
  logic          queue_wr;

  // Per-request pulses.
  logic          rx_now, perr_now, drop_now;
  logic [4:0]    ph;
  logic [7:0]    tx_bits;
  logic          tx_par;

  // Result register.
  logic          out_valid;
  logic          accept;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    wrap_inc = (idx == AW'(TX_QUEUE_DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  // One step of the line machine or one queue push.
  always_comb begin
    phase_next         = phase;
    clk_released_next  = clk_released;
    clock_drive_next   = clock_drive;
    data_drive_next    = data_drive;
    bad_frame_next     = bad_frame;
    receive_shift_next = receive_shift;
    send_shift_next    = send_shift;
    parity_acc_next    = parity_acc;
    queue_head_next    = queue_head;
    queue_tail_next    = queue_tail;
    queue_fill_next    = queue_fill;
    queue_wr           = 1'b0;
    rx_now             = 1'b0;
    perr_now           = 1'b0;
    drop_now           = 1'b0;
    tx_bits            = send_shift;
    tx_par             = parity_acc;
    // A phase code with no meaning acts as idle start.
    ph = (phase > PH_TX_AFTER) ? PH_IDLE_START : phase;

    if (req.opcode == OP_PUSH) begin
      if (queue_fill == CW'(TX_QUEUE_DEPTH)) begin
        drop_now = 1'b1;
      end else begin
        queue_wr        = 1'b1;
        queue_tail_next = wrap_inc(queue_tail);
        queue_fill_next = queue_fill + CW'(1);
      end
    end else begin
      phase_next = ph;
      if (ph <= PH_IDLE_READY) begin
        // Idle: watch for a host request or start sending a queued byte.
        data_drive_next = 1'b0;
        if (!clk_released) begin
          clk_released_next = 1'b1;
          clock_drive_next  = 1'b0;
        end else if (!req.clock_line) begin
          phase_next = PH_IDLE_WAIT;
        end else if (ph == PH_IDLE_WAIT) begin
          phase_next = req.data_line ? PH_IDLE_READY : PH_RX_START;
        end else if (ph == PH_IDLE_READY) begin
          if (queue_fill != '0) begin
            data_drive_next = 1'b1;
            phase_next      = PH_TX_START;
          end
        end else begin
          phase_next = PH_IDLE_READY;
        end
      end else if (ph <= PH_RX_ACK) begin
        // Receive: clock in the host frame.
        if (!clk_released) begin
          clk_released_next = 1'b1;
          clock_drive_next  = 1'b0;
        end else if (!req.clock_line) begin
          data_drive_next = 1'b0;
          phase_next      = PH_IDLE_WAIT;
        end else if (ph == PH_RX_START) begin
          bad_frame_next = 1'b0;
          phase_next     = ph + 5'd1;
        end else if (ph == PH_RX_ACK) begin
          data_drive_next = 1'b0;
          phase_next      = PH_IDLE_START;
        end else begin
          if (ph == PH_RX_D0) begin
            receive_shift_next = {req.data_line, 7'd0};
            parity_acc_next    = req.data_line;
          end else if (ph > PH_RX_D0 && ph <= PH_RX_D7) begin
            receive_shift_next = {req.data_line, receive_shift[7:1]};
            parity_acc_next    = parity_acc ^ req.data_line;
          end else if (ph == PH_RX_PARITY) begin
            parity_acc_next = parity_acc ^ req.data_line;
            if (!parity_acc_next) begin
              bad_frame_next = 1'b1;
            end
          end else if (ph == PH_RX_STOP) begin
            if (!bad_frame) begin
              data_drive_next = 1'b1;
              rx_now          = 1'b1;
            end else begin
              perr_now = 1'b1;
            end
          end
          clock_drive_next  = 1'b1;
          clk_released_next = 1'b0;
          phase_next        = ph + 5'd1;
        end
      end else begin
        // Transmit: send the head byte with odd parity and a stop bit.
        if (clk_released) begin
          if (!req.clock_line) begin
            data_drive_next = 1'b0;
            phase_next      = PH_IDLE_WAIT;
          end else begin
            clk_released_next = 1'b0;
            clock_drive_next  = 1'b1;
          end
        end else begin
          clk_released_next = 1'b1;
          clock_drive_next  = 1'b0;
          if (ph == PH_TX_AFTER) begin
            phase_next = PH_IDLE_START;
          end else begin
            if (ph <= PH_TX_D7) begin
              if (ph == PH_TX_START) begin
                tx_bits = head_data;
                tx_par  = 1'b0;
              end
              data_drive_next = !tx_bits[0];
              parity_acc_next = tx_par ^ tx_bits[0];
              send_shift_next = {1'b0, tx_bits[7:1]};
            end else if (ph == PH_TX_PARITY) begin
              data_drive_next = parity_acc;
              if (queue_fill != '0) begin
                queue_fill_next = queue_fill - CW'(1);
                queue_head_next = wrap_inc(queue_head);
              end
            end else begin
              data_drive_next = 1'b0;
            end
            phase_next = ph + 5'd1;
          end
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE_START;
      clk_released  <= 1'b1;
      clock_drive   <= 1'b0;
      data_drive    <= 1'b0;
      bad_frame     <= 1'b0;
      receive_shift <= 8'd0;
      send_shift    <= 8'd0;
      parity_acc    <= 1'b0;
      queue_head    <= '0;
      queue_tail    <= '0;
      queue_fill    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      clk_released  <= clk_released_next;
      clock_drive   <= clock_drive_next;
      data_drive    <= data_drive_next;
      bad_frame     <= bad_frame_next;
      receive_shift <= receive_shift_next;
      send_shift    <= send_shift_next;
      parity_acc    <= parity_acc_next;
      queue_head    <= queue_head_next;
      queue_tail    <= queue_tail_next;
      queue_fill    <= queue_fill_next;
    end
  end

  // Queue memory with a registered read of the entry at the next head.
  always_ff @(posedge clk) begin
    if (accept && queue_wr) begin
      tx_mem[queue_tail] <= req.tx_byte;
    end
    if (accept && queue_wr && (queue_tail == queue_head_next)) begin
      head_data <= req.tx_byte;
    end else if (accept) begin
      head_data <= tx_mem[queue_head_next];
    end else begin
      head_data <= tx_mem[queue_head];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.clock_pull_low <= clock_drive_next;
      rsp.data_pull_low  <= data_drive_next;
      rsp.rx_valid       <= rx_now;
      rsp.rx_data        <= rx_now ? receive_shift_next : 8'd0;
      rsp.parity_error   <= perr_now;
      rsp.tx_queue_count <= queue_fill_next;
      rsp.tx_dropped     <= drop_now;
    end
  end

  assign rsp.valid = out_valid;

`ifndef ASSERT_OFF
  // A dropped push is only reported with a full queue.
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.tx_dropped |-> rsp.tx_queue_count == CW'(TX_QUEUE_DEPTH))
    else $error("tx_dropped reported while the queue was not full");

  // A frame is either accepted or rejected, never both.
  a_rx_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(rsp.rx_valid && rsp.parity_error))
    else $error("rx_valid and parity_error set together");

  // A good byte is always acknowledged by pulling data low.
  a_rx_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && rsp.rx_valid |-> rsp.data_pull_low)
    else $error("received byte without acknowledge");

  // The fill count stays within the queue depth.
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    queue_fill <= CW'(TX_QUEUE_DEPTH))
    else $error("queue fill count exceeds depth");

  // Every accepted request leaves a result in the register.
  a_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request produced no result");
`endif

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the PS/2 device-side transceiver with host line emulation.
`timescale 1ns / 1ps

module tb;
  import ps2dt_pkg::*;

  // Line machine phase codes tracked by the predictor.
  localparam logic [4:0] PH_IDLE_START = 5'd0;
  localparam logic [4:0] PH_IDLE_WAIT = 5'd1;
  localparam logic [4:0] PH_IDLE_READY = 5'd2;
  localparam logic [4:0] PH_RX_START = 5'd3;
  localparam logic [4:0] PH_RX_D0 = 5'd5;
  localparam logic [4:0] PH_RX_D7 = 5'd12;
  localparam logic [4:0] PH_RX_PARITY = 5'd13;
  localparam logic [4:0] PH_RX_STOP = 5'd14;
  localparam logic [4:0] PH_RX_ACK = 5'd15;
  localparam logic [4:0] PH_TX_START = 5'd16;
  localparam logic [4:0] PH_TX_D7 = 5'd23;
  localparam logic [4:0] PH_TX_PARITY = 5'd24;
  localparam logic [4:0] PH_TX_AFTER = 5'd26;

  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT = 10000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic                      clock_pull_low;
    logic                      data_pull_low;
    logic                      rx_valid;
    logic [7:0]                rx_data;
    logic                      parity_error;
    logic [TX_COUNT_W_DEF-1:0] tx_queue_count;
    logic                      tx_dropped;
  } line_status_t;

  logic clk = 1'b0;
  logic rst;

  ps2dt_req_if req_ch ();
  ps2dt_rsp_if rsp_ch ();

  ps2_device_side_transceiver dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predictor copy of the line machine and transmit queue.
  logic [4:0] st_phase = PH_IDLE_START;
  logic       st_clk_free = 1'b1;
  logic       st_clk_low = 1'b0;
  logic       st_dat_low = 1'b0;
  logic       st_bad_frame = 1'b0;
  logic [7:0] st_rx_sr = 8'h00;
  logic [7:0] st_tx_sr = 8'h00;
  logic       st_parity = 1'b0;
  logic [7:0] txq_mem [TX_QUEUE_DEPTH_DEF];
  logic [3:0] txq_head = 4'd0;
  logic [3:0] txq_tail = 4'd0;
  logic [TX_COUNT_W_DEF-1:0] txq_fill = '0;

  line_status_t predicted_status_q [$];

  int err_count = 0;
  int sent_count = 0;
  bit src_gaps_on = 1'b1;
  bit snk_gaps_on = 1'b1;
  bit hold_request = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the predicted line machine by one request and return its status.
  function automatic line_status_t line_step(logic op, logic cl, logic dl, logic [7:0] b);
    line_status_t s;
    logic rx_ok;
    logic rx_bad;
    logic dropped;
    rx_ok = 1'b0;
    rx_bad = 1'b0;
    dropped = 1'b0;
    if (op == OP_PUSH) begin
      if (txq_fill >= TX_COUNT_W_DEF'(TX_QUEUE_DEPTH_DEF)) begin
        dropped = 1'b1;
      end else begin
        txq_mem[txq_tail] = b;
        txq_tail = txq_tail + 4'd1;
        txq_fill = txq_fill + TX_COUNT_W_DEF'(1);
      end
    end else begin
      if (st_phase > PH_TX_AFTER) st_phase = PH_IDLE_START;
      if (st_phase <= PH_IDLE_READY) begin
        // Idle: wait for a host request or for queued bytes to send.
        st_dat_low = 1'b0;
        if (!st_clk_free) begin
          st_clk_free = 1'b1;
          st_clk_low = 1'b0;
        end else if (!cl) begin
          st_phase = PH_IDLE_WAIT;
        end else if (st_phase == PH_IDLE_WAIT) begin
          st_phase = dl ? PH_IDLE_READY : PH_RX_START;
        end else if (st_phase == PH_IDLE_READY) begin
          if (txq_fill != 0) begin
            st_dat_low = 1'b1;
            st_phase = PH_TX_START;
          end
        end else begin
          st_phase = PH_IDLE_READY;
        end
      end else if (st_phase <= PH_RX_ACK) begin
        // Receive: sample on the released half, then pull the clock low.
        if (!st_clk_free) begin
          st_clk_free = 1'b1;
          st_clk_low = 1'b0;
        end else if (!cl) begin
          st_dat_low = 1'b0;
          st_phase = PH_IDLE_WAIT;
        end else if (st_phase == PH_RX_START) begin
          st_bad_frame = 1'b0;
          st_phase = st_phase + 5'd1;
        end else if (st_phase == PH_RX_ACK) begin
          st_dat_low = 1'b0;
          st_phase = PH_IDLE_START;
        end else begin
          if (st_phase == PH_RX_D0) begin
            st_rx_sr = {dl, 7'd0};
            st_parity = dl;
          end else if (st_phase > PH_RX_D0 && st_phase <= PH_RX_D7) begin
            st_rx_sr = {dl, st_rx_sr[7:1]};
            st_parity = st_parity ^ dl;
          end else if (st_phase == PH_RX_PARITY) begin
            st_parity = st_parity ^ dl;
            if (!st_parity) st_bad_frame = 1'b1;
          end else if (st_phase == PH_RX_STOP) begin
            if (!st_bad_frame) begin
              st_dat_low = 1'b1;
              rx_ok = 1'b1;
            end else begin
              rx_bad = 1'b1;
            end
          end
          st_clk_low = 1'b1;
          st_clk_free = 1'b0;
          st_phase = st_phase + 5'd1;
        end
      end else begin
        // Transmit: drive each bit as the clock is released and hold it while the clock is pulled low.
        if (st_clk_free) begin
          if (!cl) begin
            st_dat_low = 1'b0;
            st_phase = PH_IDLE_WAIT;
          end else begin
            st_clk_free = 1'b0;
            st_clk_low = 1'b1;
          end
        end else begin
          st_clk_free = 1'b1;
          st_clk_low = 1'b0;
          if (st_phase == PH_TX_AFTER) begin
            st_phase = PH_IDLE_START;
          end else begin
            if (st_phase <= PH_TX_D7) begin
              if (st_phase == PH_TX_START) begin
                st_tx_sr = txq_mem[txq_head];
                st_parity = 1'b0;
              end
              st_dat_low = ~st_tx_sr[0];
              st_parity = st_parity ^ st_tx_sr[0];
              st_tx_sr = st_tx_sr >> 1;
            end else if (st_phase == PH_TX_PARITY) begin
              st_dat_low = st_parity;
              if (txq_fill != 0) begin
                txq_fill = txq_fill - TX_COUNT_W_DEF'(1);
                txq_head = txq_head + 4'd1;
              end
            end else begin
              st_dat_low = 1'b0;
            end
            st_phase = st_phase + 5'd1;
          end
        end
      end
    end
    s.clock_pull_low = st_clk_low;
    s.data_pull_low = st_dat_low;
    s.rx_valid = rx_ok;
    s.rx_data = rx_ok ? st_rx_sr : 8'h00;
    s.parity_error = rx_bad;
    s.tx_queue_count = txq_fill;
    s.tx_dropped = dropped;
    return s;
  endfunction

  // Mostly short idle stretches with an occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_error(string msg);
    if (err_count < PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Offer one request, wait for it to be taken, then record its predicted status.
  task automatic send_request(logic op, logic cl, logic dl, logic [7:0] b);
    int gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.clock_line <= cl;
    req_ch.data_line <= dl;
    req_ch.tx_byte <= b;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted_status_q.push_back(line_step(op, cl, dl, b));
    sent_count++;
  endtask

  task automatic push_random();
    send_request(OP_PUSH, $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                 8'($urandom_range(0, 255)));
  endtask

  // One half-bit tick seen through the open-drain lines: the host and the block both pull.
  task automatic host_tick(logic host_clk, logic host_dat);
    send_request(OP_TICK, host_clk & ~st_clk_low, host_dat & ~st_dat_low,
                 8'($urandom_range(0, 255)));
  endtask

  task automatic noise_item();
    if ($urandom_range(0, 5) == 0) push_random();
    else send_request(OP_TICK, $urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
                      8'($urandom_range(0, 255)));
  endtask

  // Host sends one byte: request to send, then present bits while the block clocks.
  task automatic host_frame(logic [7:0] b, bit bad_par, bit may_abort);
    logic [9:0] bits;
    int abort_at;
    int k;
    bits = {$urandom_range(0, 1) != 0, (~^b) ^ bad_par, b};
    abort_at = -1;
    if (may_abort) abort_at = $urandom_range(0, 25);
    host_tick(1'b0, 1'b1);
    while (st_phase != PH_IDLE_WAIT) host_tick(1'b0, 1'b1);
    repeat ($urandom_range(0, 2)) host_tick(1'b0, 1'b1);
    host_tick(1'b1, 1'b0);
    k = 0;
    while (st_phase >= PH_RX_START && st_phase <= PH_RX_ACK) begin
      if (k == abort_at) host_tick(1'b0, 1'b1);
      else if (st_phase >= PH_RX_D0 && st_phase <= PH_RX_STOP)
        host_tick(1'b1, bits[4'(st_phase - PH_RX_D0)]);
      else host_tick(1'b1, st_phase == PH_RX_ACK);
      if ($urandom_range(0, 11) == 0) push_random();
      k++;
    end
  endtask

  // Block sends the head of its queue while the host leaves both lines released, unless the host aborts it.
  task automatic device_frame(bit may_abort);
    int abort_at;
    int k;
    abort_at = -1;
    if (may_abort) abort_at = $urandom_range(0, 24);
    k = 0;
    while (st_phase < PH_TX_START && k < 4) begin
      host_tick(1'b1, 1'b1);
      k++;
    end
    k = 0;
    while (st_phase >= PH_TX_START) begin
      if (k == abort_at) host_tick(1'b0, 1'b1);
      else host_tick(1'b1, 1'b1);
      if ($urandom_range(0, 39) == 0) push_random();
      k++;
    end
  endtask

  // Idle line watching, including a host request aborted at its start bit.
  task automatic test_idle_lines();
    send_request(OP_TICK, 1'b1, 1'b1, 8'h00);
    send_request(OP_TICK, 1'b0, 1'b0, 8'hFF);
    send_request(OP_TICK, 1'b0, 1'b1, 8'h00);
    send_request(OP_TICK, 1'b1, 1'b1, 8'hFF);
    send_request(OP_TICK, 1'b1, 1'b0, 8'h00);
    send_request(OP_TICK, 1'b0, 1'b0, 8'hFF);
    send_request(OP_TICK, 1'b1, 1'b0, 8'h00);
    send_request(OP_TICK, 1'b0, 1'b1, 8'hFF);
    send_request(OP_TICK, 1'b1, 1'b1, 8'h00);
  endtask

  // Fill the transmit queue with extreme and random bytes, then overflow it once.
  task automatic test_queue_full();
    send_request(OP_PUSH, 1'b0, 1'b0, 8'h00);
    send_request(OP_PUSH, 1'b1, 1'b1, 8'hFF);
    repeat (TX_QUEUE_DEPTH_DEF - 2) push_random();
    send_request(OP_PUSH, 1'b1, 1'b0, 8'hA5);
  endtask

  // Drain the queue through device-to-host frames, some cut short by the host.
  task automatic test_device_frames();
    while (sent_count < 350) begin
      src_gaps_on = $urandom_range(0, 3) != 0;
      snk_gaps_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(1, 5)) push_random();
      while (txq_fill != 0 && sent_count < 350) device_frame($urandom_range(0, 7) == 0);
    end
  endtask

  // Host-to-device frames with random bytes, some bad parity and some aborts.
  task automatic test_host_frames();
    while (sent_count < 700) begin
      src_gaps_on = $urandom_range(0, 3) != 0;
      snk_gaps_on = $urandom_range(0, 3) != 0;
      host_frame(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                 $urandom_range(0, 7) == 0);
    end
  endtask

  // Hold the result side for a long stretch while requests keep coming.
  task automatic test_output_stall();
    src_gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (20) push_random();
    host_frame(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    src_gaps_on = 1'b1;
  endtask

  // Interleave both frame directions with bursts of random line levels.
  task automatic test_mixed_traffic();
    int r;
    while (sent_count < 1050) begin
      src_gaps_on = $urandom_range(0, 3) != 0;
      snk_gaps_on = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 9);
      if (r < 4) begin
        host_frame(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0,
                   $urandom_range(0, 5) == 0);
      end else if (r < 7) begin
        if (txq_fill == 0) repeat ($urandom_range(1, 3)) push_random();
        device_frame($urandom_range(0, 5) == 0);
      end else begin
        repeat ($urandom_range(5, 20)) noise_item();
      end
    end
  endtask

  // Result side: random stalls, plus one long hold when a test asks for it.
  initial begin : rsp_drain
    int n;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = snk_gaps_on ? pick_gap() : 0;
        if (n > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Compare every accepted result with the oldest predicted status.
  always @(posedge clk) begin : status_check
    line_status_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (predicted_status_q.size() == 0) begin
        report_error("result with no request outstanding");
      end else begin
        want = predicted_status_q.pop_front();
        check_field("clock_pull_low", 8'(rsp_ch.clock_pull_low), 8'(want.clock_pull_low));
        check_field("data_pull_low", 8'(rsp_ch.data_pull_low), 8'(want.data_pull_low));
        check_field("rx_valid", 8'(rsp_ch.rx_valid), 8'(want.rx_valid));
        check_field("rx_data", rsp_ch.rx_data, want.rx_data);
        check_field("parity_error", 8'(rsp_ch.parity_error), 8'(want.parity_error));
        check_field("tx_queue_count", 8'(rsp_ch.tx_queue_count), 8'(want.tx_queue_count));
        check_field("tx_dropped", 8'(rsp_ch.tx_dropped), 8'(want.tx_dropped));
      end
    end
  end

  // Main sequence: reset, run the tests in turn, drain and report.
  initial begin : main_seq
    int waited;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_TICK;
    req_ch.clock_line = 1'b1;
    req_ch.data_line = 1'b1;
    req_ch.tx_byte = 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_idle_lines();
    test_queue_full();
    test_device_frames();
    test_host_frames();
    test_output_stall();
    test_mixed_traffic();
    req_ch.valid <= 1'b0;
    waited = 0;
    while (predicted_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (predicted_status_q.size() != 0)
      report_error($sformatf("%0d results never arrived", predicted_status_q.size()));
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
